// ----- hw/rtl/mrjr_pkg.sv -----
// mrjr_pkg: shared types and constants of the motor run/jog ramp controller
// item payload structs, configuration struct, key codes and register indexes
// no dependencies
package mrjr_pkg;

    // widths of the fields
    localparam int SpeedW = 14;
    localparam int RampW  = 18;
    localparam int KeyW   = 3;
    localparam int FracW  = 4;

    // reset values
    localparam logic [SpeedW-1:0] DEFAULT_SPEED   = 14'd200;
    localparam logic [SpeedW-1:0] RST_MAX_SPEED   = 14'd16383;
    localparam logic [SpeedW-1:0] RST_SPEED_STEP  = 14'd10;
    localparam logic [RampW-1:0]  RST_RAMP_STEP   = 18'd16;

    // item kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_CTRL = 1'b1;

    // key event codes
    localparam logic [KeyW-1:0] KEY_NONE = 3'd0;
    localparam logic [KeyW-1:0] KEY_UP   = 3'd1;
    localparam logic [KeyW-1:0] KEY_DOWN = 3'd2;
    localparam logic [KeyW-1:0] KEY_RUN  = 3'd3;
    localparam logic [KeyW-1:0] KEY_DIR  = 3'd4;

    // configuration port
    localparam int AddrW = 4;
    localparam int DataW = 32;
    localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] REG_SPEED_STEP = 2'd1;
    localparam logic [1:0] REG_RAMP_STEP  = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [KeyW-1:0]   key_event;
        logic              jog_fwd_held;
        logic              jog_rev_held;
    } t_in;

    typedef struct packed {
        logic [SpeedW-1:0] target_speed;
        logic [RampW-1:0]  ramp_setpoint;
        logic              driving;
        logic              forward;
        logic              jog_on;
        logic              loop_clear;
        logic              loop_update;
    } t_out;

    typedef struct packed {
        logic [SpeedW-1:0] max_speed;
        logic [SpeedW-1:0] speed_step;
        logic [RampW-1:0]  ramp_step;
    } t_cfg;

endpackage

// ----- hw/rtl/mrjr_cfg.sv -----
// mrjr_cfg: apb-style register file holding max_speed, speed_step and ramp_step
// depends on mrjr_pkg
module mrjr_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mrjr_pkg::AddrW-1:0] paddr,
    input  logic [mrjr_pkg::DataW-1:0] pwdata,
    output logic [mrjr_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output mrjr_pkg::t_cfg             o_cfg
);

    mrjr_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    // register writes at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed  <= mrjr_pkg::RST_MAX_SPEED;
            r_cfg.speed_step <= mrjr_pkg::RST_SPEED_STEP;
            r_cfg.ramp_step  <= mrjr_pkg::RST_RAMP_STEP;
        end else if (wr_en) begin
            unique case (reg_idx)
                mrjr_pkg::REG_MAX_SPEED:  r_cfg.max_speed  <= pwdata[mrjr_pkg::SpeedW-1:0];
                mrjr_pkg::REG_SPEED_STEP: r_cfg.speed_step <= pwdata[mrjr_pkg::SpeedW-1:0];
                mrjr_pkg::REG_RAMP_STEP:  r_cfg.ramp_step  <= pwdata[mrjr_pkg::RampW-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            mrjr_pkg::REG_MAX_SPEED:
                prdata = {{(mrjr_pkg::DataW-mrjr_pkg::SpeedW){1'b0}}, r_cfg.max_speed};
            mrjr_pkg::REG_SPEED_STEP:
                prdata = {{(mrjr_pkg::DataW-mrjr_pkg::SpeedW){1'b0}}, r_cfg.speed_step};
            mrjr_pkg::REG_RAMP_STEP:
                prdata = {{(mrjr_pkg::DataW-mrjr_pkg::RampW){1'b0}}, r_cfg.ramp_step};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/mrjr_core.sv -----
// mrjr_core: run/jog/target/ramp state and the result register
// takes one registered item per cycle while the result register is empty or taken; depends on mrjr_pkg
module mrjr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mrjr_pkg::t_in  i_item,
    input  mrjr_pkg::t_cfg i_cfg,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mrjr_pkg::t_out o_out
);

    logic                        r_run;
    logic                        r_run_fwd;
    logic                        r_jog;
    logic                        r_jog_fwd;
    logic [mrjr_pkg::SpeedW-1:0] r_target;
    logic [mrjr_pkg::RampW-1:0]  r_ramp;
    logic                        r_out_valid;
    mrjr_pkg::t_out              r_out;

    logic                        n_run;
    logic                        n_run_fwd;
    logic                        n_jog;
    logic                        n_jog_fwd;
    logic [mrjr_pkg::SpeedW-1:0] n_target;
    logic [mrjr_pkg::RampW-1:0]  n_ramp;
    logic                        n_clr;
    logic                        n_upd;

    logic                        one_held;
    logic [mrjr_pkg::SpeedW:0]   up_sum;
    logic [mrjr_pkg::RampW-1:0]  goal;
    logic [mrjr_pkg::RampW:0]    ramp_up;
    logic [mrjr_pkg::RampW-1:0]  ramp_dn;

    // result register frees up when empty or taken
    assign o_take      = i_valid & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign one_held = i_item.jog_fwd_held ^ i_item.jog_rev_held;
    assign up_sum   = {1'b0, r_target} + {1'b0, i_cfg.speed_step};
    assign goal     = {r_target, {mrjr_pkg::FracW{1'b0}}};
    assign ramp_up  = {1'b0, r_ramp} + {1'b0, i_cfg.ramp_step};
    assign ramp_dn  = r_ramp - i_cfg.ramp_step;

    // next state for one item
    always_comb begin
        n_run     = r_run;
        n_run_fwd = r_run_fwd;
        n_jog     = r_jog;
        n_jog_fwd = r_jog_fwd;
        n_target  = r_target;
        n_ramp    = r_ramp;
        n_clr     = 1'b0;
        n_upd     = 1'b0;
        if (i_item.kind == mrjr_pkg::KIND_KEY) begin
            // jog entry and exit
            if (one_held && !r_run) begin
                if (!r_jog) begin
                    n_jog     = 1'b1;
                    n_jog_fwd = i_item.jog_fwd_held;
                    n_ramp    = '0;
                    n_clr     = 1'b1;
                end
            end else if (r_jog) begin
                n_jog = 1'b0;
                n_clr = 1'b1;
            end
            // key events only while jog is off
            if (!n_jog) begin
                case (i_item.key_event)
                    mrjr_pkg::KEY_UP: begin
                        if (up_sum > {1'b0, i_cfg.max_speed}) begin
                            n_target = i_cfg.max_speed;
                        end else begin
                            n_target = up_sum[mrjr_pkg::SpeedW-1:0];
                        end
                    end
                    mrjr_pkg::KEY_DOWN: begin
                        if (r_target < i_cfg.speed_step) begin
                            n_target = '0;
                        end else begin
                            n_target = r_target - i_cfg.speed_step;
                        end
                    end
                    mrjr_pkg::KEY_RUN: begin
                        n_run = ~r_run;
                        if (r_run) begin
                            n_clr = 1'b1;
                        end
                    end
                    mrjr_pkg::KEY_DIR: begin
                        if (!r_run) begin
                            n_run_fwd = ~r_run_fwd;
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            // ramp toward the target while driving, else clear the ramp and the loop
            if (r_run || r_jog) begin
                if (ramp_up < {1'b0, goal}) begin
                    n_ramp = ramp_up[mrjr_pkg::RampW-1:0];
                end else if (r_ramp > i_cfg.ramp_step && ramp_dn > goal) begin
                    n_ramp = ramp_dn;
                end else begin
                    n_ramp = goal;
                end
                n_upd = 1'b1;
            end else begin
                n_ramp = '0;
                n_clr  = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_run_fwd <= 1'b1;
            r_jog     <= 1'b0;
            r_jog_fwd <= 1'b1;
            r_target  <= mrjr_pkg::DEFAULT_SPEED;
            r_ramp    <= '0;
        end else if (o_take) begin
            r_run     <= n_run;
            r_run_fwd <= n_run_fwd;
            r_jog     <= n_jog;
            r_jog_fwd <= n_jog_fwd;
            r_target  <= n_target;
            r_ramp    <= n_ramp;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.target_speed  <= n_target;
            r_out.ramp_setpoint <= n_ramp;
            r_out.driving       <= n_run | n_jog;
            r_out.forward       <= n_jog ? n_jog_fwd : n_run_fwd;
            r_out.jog_on        <= n_jog;
            r_out.loop_clear    <= n_clr;
            r_out.loop_update   <= n_upd;
        end
    end

endmodule

// ----- hw/rtl/motor_run_jog_ramp_control.sv -----
// motor_run_jog_ramp_control: top level with input register, core and apb registers
// depends on mrjr_pkg, mrjr_cfg, mrjr_core
// an accepted item passes the input register, then the core's result register, before it is valid
// throughput: one item per cycle while results are taken; input register feeds the core's result register
// the input side keeps taking items while a result waits, until both stages are full
// reset: synchronous, active low; clears run/jog state, target to 200, ramp to 0,
// registers to their reset values
module motor_run_jog_ramp_control (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mrjr_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mrjr_pkg::t_out             o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mrjr_pkg::AddrW-1:0] paddr,
    input  logic [mrjr_pkg::DataW-1:0] pwdata,
    output logic [mrjr_pkg::DataW-1:0] prdata,
    output logic                       pready
);

    logic           r_in_valid;
    mrjr_pkg::t_in  r_in;
    logic           core_take;
    mrjr_pkg::t_cfg cfg;

    assign o_in_ready = ~r_in_valid | core_take;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    mrjr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mrjr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_take      (core_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- hw/rtl/mrjr_checker.sv -----
// mrjr_checker: port-level assertions for motor_run_jog_ramp_control, with its bind
// depends on mrjr_pkg
module mrjr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mrjr_pkg::t_out o_out
);

    // a waiting result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result item dropped or changed while stalled");

    // speed loop is only evaluated while driving
    a_upd_driving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.loop_update |-> o_out.driving)
        else $error("loop_update without driving");

    // jog implies motor enabled
    a_jog_driving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.jog_on |-> o_out.driving)
        else $error("jog_on without driving");

    // clear and update never in the same item
    a_clr_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.loop_clear && o_out.loop_update))
        else $error("loop_clear and loop_update together");

endmodule

bind motor_run_jog_ramp_control mrjr_checker u_mrjr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
